>>> design/m4m_pkg.sv
`default_nettype none
package m4m_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned ProdW = 2 * ElemW;
  localparam int unsigned PosW  = 4;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic [PosW-1:0]         pos_t;

  localparam elem_t ElemMax = elem_t'(32'sh7FFF_FFFF);
  localparam elem_t ElemMin = elem_t'(32'sh8000_0000);

endpackage
`default_nettype wire

>>> design/matrix4_multiply_core.sv
`default_nettype none
// matrix4_multiply_core: C = A x B for two DIM x DIM fixed-point matrices.
//
// Load: one request per cycle, start_i high while busy_o is low. Each request
// carries A and B elements at the same column-major position. The request
// that completes the load (the DIM*DIM-th) raises busy_o at the next edge.
// Compute: a chain of DIM cells; cell k holds column k of A and row k of B
// and adds A[row][k]*B[k][col] into a sum handed on to cell k+1. Each cell
// registers its multiply, then its accumulate. One position enters the
// chain each cycle, so results leave one per cycle, column-major.
// From the completing request, each position passes the issue register,
// the multiply and accumulate registers of every cell and the rounding
// register; the DIM*DIM results follow back to back on valid_o, last_o
// marks the final one. busy_o drops at the edge that takes that last result.
// busy_o stays high through the whole product, so a new load is taken only
// after the last result; chain depth and the single stream of positions
// bound the rate. Sum is floor-shifted by FRAC_BITS, saturated to 32 bits.
// The receiver cannot stall; results are shown for one cycle only.
// Reset (async, active low) clears the load position and all strobes; the
// element stores hold no reset value and are fully written before use.
module matrix4_multiply_core import m4m_pkg::*; #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start_i,
  output logic  busy_o,
  input  elem_t a_elem_i,
  input  elem_t b_elem_i,
  output logic  valid_o,
  output elem_t c_elem_o,
  output pos_t  position_o,
  output logic  last_o
);

  localparam int unsigned Cells = DIM * DIM;
  localparam int unsigned IdxW  = $clog2(DIM);
  localparam int unsigned CntW  = $clog2(Cells);
  localparam int unsigned SumW  = ProdW + $clog2(DIM);

  // load position
  logic [IdxW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic            accept, ld_last;

  // issue counters feeding the chain
  logic            iss_q, iss_d;
  logic [IdxW-1:0] iss_row_q, iss_row_d, iss_col_q, iss_col_d;
  logic [CntW-1:0] iss_pos_q, iss_pos_d;
  logic            busy_q, busy_d;

  assign accept  = start_i && !busy_q;
  assign ld_last = (ld_row_q == IdxW'(DIM - 1)) && (ld_col_q == IdxW'(DIM - 1));
  assign busy_o  = busy_q;

  always_comb begin
    ld_row_d  = ld_row_q;
    ld_col_d  = ld_col_q;
    iss_d     = iss_q;
    iss_row_d = iss_row_q;
    iss_col_d = iss_col_q;
    iss_pos_d = iss_pos_q;
    busy_d    = busy_q;

    if (accept) begin
      if (ld_row_q == IdxW'(DIM - 1)) begin
        ld_row_d = '0;
        ld_col_d = (ld_col_q == IdxW'(DIM - 1)) ? '0 : ld_col_q + 1'b1;
      end else begin
        ld_row_d = ld_row_q + 1'b1;
      end
      if (ld_last) begin
        busy_d    = 1'b1;
        iss_d     = 1'b1;
        iss_row_d = '0;
        iss_col_d = '0;
        iss_pos_d = '0;
      end
    end

    if (iss_q) begin
      iss_pos_d = iss_pos_q + 1'b1;
      if (iss_row_q == IdxW'(DIM - 1)) begin
        iss_row_d = '0;
        iss_col_d = iss_col_q + 1'b1;
      end else begin
        iss_row_d = iss_row_q + 1'b1;
      end
      if (iss_pos_q == CntW'(Cells - 1)) begin
        iss_d = 1'b0;
      end
    end

    // last result leaves: the block is free again
    if (valid_o && last_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
      iss_q    <= 1'b0;
      busy_q   <= 1'b0;
    end else begin
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      iss_q    <= iss_d;
      busy_q   <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_row_q <= iss_row_d;
    iss_col_q <= iss_col_d;
    iss_pos_q <= iss_pos_d;
  end

  // chain links: index 0 is the issue point, index DIM the chain output
  logic                   ch_valid [DIM+1];
  logic [IdxW-1:0]        ch_row   [DIM+1];
  logic [IdxW-1:0]        ch_col   [DIM+1];
  logic [CntW-1:0]        ch_pos   [DIM+1];
  logic signed [SumW-1:0] ch_sum   [DIM+1];

  assign ch_valid[0] = iss_q;
  assign ch_row[0]   = iss_row_q;
  assign ch_col[0]   = iss_col_q;
  assign ch_pos[0]   = iss_pos_q;
  assign ch_sum[0]   = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    m4m_cell #(
      .DIM      (DIM),
      .CELL_IDX (k),
      .SUM_W    (SumW),
      .IDX_W    (IdxW),
      .CNT_W    (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ld_we_i  (accept),
      .ld_row_i (ld_row_q),
      .ld_col_i (ld_col_q),
      .ld_a_i   (a_elem_i),
      .ld_b_i   (b_elem_i),
      .valid_i  (ch_valid[k]),
      .row_i    (ch_row[k]),
      .col_i    (ch_col[k]),
      .pos_i    (ch_pos[k]),
      .sum_i    (ch_sum[k]),
      .valid_o  (ch_valid[k+1]),
      .row_o    (ch_row[k+1]),
      .col_o    (ch_col[k+1]),
      .pos_o    (ch_pos[k+1]),
      .sum_o    (ch_sum[k+1])
    );
  end

  m4m_round #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SumW),
    .CNT_W     (CntW)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (ch_valid[DIM]),
    .pos_i      (ch_pos[DIM]),
    .sum_i      (ch_sum[DIM]),
    .valid_o    (valid_o),
    .c_elem_o   (c_elem_o),
    .position_o (position_o),
    .last_o     (last_o)
  );

`ifndef ASSERT_OFF
  // results only come out of a product in flight
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_q) else $error("result strobe while idle");

  // results of one product form an unbroken burst
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o) else $error("gap in result burst");

  // the final result frees the block
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !busy_q) else $error("busy after last result");

  // a completed load starts a product
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ld_last |=> busy_q && iss_q) else $error("load end not issued");
`endif

endmodule
`default_nettype wire

>>> design/m4m_cell.sv
`default_nettype none
// One tap of the dot-product chain: holds column CELL_IDX of A and row
// CELL_IDX of B, adds its product into the running sum in two stages.
module m4m_cell import m4m_pkg::*; #(
  parameter int unsigned DIM      = 4,
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned SUM_W    = 66,
  parameter int unsigned IDX_W    = 2,
  parameter int unsigned CNT_W    = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // load bus
  input  wire                          ld_we_i,
  input  wire        [IDX_W-1:0]       ld_row_i,
  input  wire        [IDX_W-1:0]       ld_col_i,
  input  elem_t                        ld_a_i,
  input  elem_t                        ld_b_i,
  // chain in
  input  wire                          valid_i,
  input  wire        [IDX_W-1:0]       row_i,
  input  wire        [IDX_W-1:0]       col_i,
  input  wire        [CNT_W-1:0]       pos_i,
  input  wire signed [SUM_W-1:0]       sum_i,
  // chain out
  output logic                         valid_o,
  output logic       [IDX_W-1:0]       row_o,
  output logic       [IDX_W-1:0]       col_o,
  output logic       [CNT_W-1:0]       pos_o,
  output logic signed [SUM_W-1:0]      sum_o
);

  elem_t a_q [DIM];
  elem_t b_q [DIM];

  logic                    v1_q;
  logic [IDX_W-1:0]        row1_q, col1_q;
  logic [CNT_W-1:0]        pos1_q;
  logic signed [SUM_W-1:0] sum1_q;
  prod_t                   prod1_q;

  always_ff @(posedge clk_i) begin
    if (ld_we_i && (ld_col_i == IDX_W'(CELL_IDX))) begin
      a_q[ld_row_i] <= ld_a_i;
    end
    if (ld_we_i && (ld_row_i == IDX_W'(CELL_IDX))) begin
      b_q[ld_col_i] <= ld_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  // stage 1: multiply; stage 2: accumulate
  always_ff @(posedge clk_i) begin
    row1_q  <= row_i;
    col1_q  <= col_i;
    pos1_q  <= pos_i;
    sum1_q  <= sum_i;
    prod1_q <= prod_t'(a_q[row_i]) * prod_t'(b_q[col_i]);
    row_o   <= row1_q;
    col_o   <= col1_q;
    pos_o   <= pos1_q;
    sum_o   <= sum1_q + SUM_W'(prod1_q);
  end

endmodule
`default_nettype wire

>>> design/m4m_round.sv
`default_nettype none
// Floor shift by FRAC_BITS, saturate to 32 bits, register the result.
module m4m_round import m4m_pkg::*; #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SUM_W     = 66,
  parameter int unsigned CNT_W     = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     valid_i,
  input  wire       [CNT_W-1:0]   pos_i,
  input  wire signed [SUM_W-1:0]  sum_i,
  output logic                    valid_o,
  output elem_t                   c_elem_o,
  output pos_t                    position_o,
  output logic                    last_o
);

  localparam int unsigned Cells = DIM * DIM;

  logic signed [SUM_W-1:0] shifted;
  logic [SUM_W-ElemW:0]    upper;
  elem_t                   sat;

  always_comb begin
    shifted = sum_i >>> FRAC_BITS;
    upper   = shifted[SUM_W-1:ElemW-1];
    if (upper == '0 || upper == '1) begin
      sat = shifted[ElemW-1:0];
    end else if (shifted[SUM_W-1]) begin
      sat = ElemMin;
    end else begin
      sat = ElemMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_elem_o   <= sat;
    position_o <= PosW'(pos_i);
    last_o     <= (pos_i == CNT_W'(Cells - 1));
  end

endmodule
`default_nettype wire
